// File: rtl/dca_pkg.sv
// Package for the delayed conjugate autocorrelation block: field widths,
// reset constants and shared types. No dependencies.
`default_nettype none

package dca_pkg;

   // Fixed widths of the channel fields.
   localparam int SampleW  = 16;
   localparam int ProductW = 33;
   localparam int PowerW   = 32;
   localparam int LagW     = 9;

   typedef logic [LagW-1:0] lag_type;

   localparam lag_type LagReset = lag_type'(16);

   // Per-cell control of the delay line.
   typedef struct packed {
      logic shift;
      logic sel;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/dca_if.sv
// Channel interfaces of the block: sample items in, result items out and
// the lag write channel. Depends on dca_pkg.
`default_nettype none

interface dca_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [dca_pkg::SampleW-1:0]  sample_re;
   logic signed [dca_pkg::SampleW-1:0]  sample_im;

   modport source (output valid, output sample_re, output sample_im, input ready);
   modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface dca_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dca_pkg::ProductW-1:0] product_re;
   logic signed [dca_pkg::ProductW-1:0] product_im;
   logic [dca_pkg::PowerW-1:0]          power;

   modport source (output valid, output product_re, output product_im, output power,
                   input ready);
   modport sink   (input valid, input product_re, input product_im, input power,
                   output ready);
endinterface

interface dca_csr_if;
   logic             valid;
   logic             ready;
   dca_pkg::lag_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/delayed_conjugate_autocorrelation_top.sv
// A sample item passes the input, product and result registers of dca_cmul.
// Throughput: one item per cycle while the result channel does not stall; the
// delay tap is registered, so while a lag write is offered and in the cycle
// after it, no item is taken. Reset (synchronous) clears the whole cell row
// to zero, empties the multiply pipeline and sets the lag to 16.
// Depends on dca_pkg, dca_if, dca_delay_line and dca_cmul.
`default_nettype none

module delayed_conjugate_autocorrelation_top #(
   parameter int MAX_LAG     = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   dca_req_if.sink   req_ch,
   dca_rsp_if.source rsp_ch,
   dca_csr_if.sink   csr_ch
);

   localparam int IdxW  = $clog2(MAX_LAG);
   localparam int SizeW = $clog2(MAX_LAG + 1);
   localparam int CmpW  = (SizeW > dca_pkg::LagW) ? SizeW : dca_pkg::LagW;

   // Lag of zero acts as one, and lags past the row length saturate.
   function automatic logic [IdxW-1:0] tap_index(input dca_pkg::lag_type l);
      logic [CmpW-1:0] eff;
      eff = CmpW'(l);
      if (eff == '0) begin
         eff = CmpW'(1);
      end else if (eff > CmpW'(MAX_LAG)) begin
         eff = CmpW'(MAX_LAG);
      end
      eff = eff - CmpW'(1);
      return eff[IdxW-1:0];
   endfunction

   logic                          req_acc;
   logic                          csr_acc;
   logic                          pipe_ready;
   logic                          hold_ff, hold_in;
   logic [IdxW-1:0]               tap_idx_ff, tap_idx_in;
   logic signed [SAMPLE_BITS-1:0] x_re, x_im;
   logic [2*SAMPLE_BITS-1:0]      tap;

   if (SAMPLE_BITS <= dca_pkg::SampleW) begin : g_narrow
      assign x_re = req_ch.sample_re[SAMPLE_BITS-1:0];
      assign x_im = req_ch.sample_im[SAMPLE_BITS-1:0];
   end else begin : g_wide
      assign x_re = {{(SAMPLE_BITS - dca_pkg::SampleW){1'b0}}, req_ch.sample_re};
      assign x_im = {{(SAMPLE_BITS - dca_pkg::SampleW){1'b0}}, req_ch.sample_im};
   end

   assign csr_ch.ready = !reset;
   assign csr_acc      = csr_ch.valid && csr_ch.ready;

   assign req_ch.ready = pipe_ready && !hold_ff && !csr_ch.valid && !reset;
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign hold_in    = csr_acc;
   assign tap_idx_in = csr_acc ? tap_index(csr_ch.data) : tap_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff    <= 1'b0;
         tap_idx_ff <= tap_index(dca_pkg::LagReset);
      end else begin
         hold_ff    <= hold_in;
         tap_idx_ff <= tap_idx_in;
      end
   end

   dca_delay_line #(
      .DEPTH (MAX_LAG),
      .W     (2 * SAMPLE_BITS)
   ) u_delay (
      .clock   (clock),
      .reset   (reset),
      .shift   (req_acc),
      .d_in    ({x_re, x_im}),
      .tap_idx (tap_idx_ff),
      .tap     (tap)
   );

   dca_cmul #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_cmul (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_acc),
      .in_ready (pipe_ready),
      .x_re     (x_re),
      .x_im     (x_im),
      .d_re     (tap[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .d_im     (tap[SAMPLE_BITS-1:0]),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

// File: rtl/dca_cell.sv
// One cell of the sample delay line: holds one complex sample, passes it to
// its neighbor on each shift and offers it to the tap when selected. Uses dca_pkg.
`default_nettype none

module dca_cell #(
   parameter int W = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dca_pkg::cell_ctrl_type ctrl,
   input  wire logic [W-1:0]           d_in,
   output logic [W-1:0]                q,
   output logic [W-1:0]                contrib
);

   logic [W-1:0] data_ff;
   logic [W-1:0] data_in;

   assign data_in = ctrl.shift ? d_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;

   // The tap sees what this cell will hold after the current edge.
   assign contrib = ctrl.sel ? data_in : '0;

endmodule

`default_nettype wire

// File: rtl/dca_delay_line.sv
// Row of delay cells holding the last DEPTH samples, with a registered tap
// that holds the sample lag items back for the next item. Uses dca_cell, dca_pkg.
`default_nettype none

module dca_delay_line #(
   parameter int DEPTH = 256,
   parameter int W     = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     shift,
   input  wire logic [W-1:0]             d_in,
   input  wire logic [$clog2(DEPTH)-1:0] tap_idx,
   output logic [W-1:0]                  tap
);

   localparam int IdxW = $clog2(DEPTH);

   logic [W-1:0] q       [DEPTH];
   logic [W-1:0] contrib [DEPTH];
   logic [W-1:0] tap_ff;
   logic [W-1:0] tap_in;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      dca_pkg::cell_ctrl_type ctrl;
      logic [W-1:0]           cell_d;

      assign ctrl.shift = shift;
      assign ctrl.sel   = (tap_idx == IdxW'(k));

      if (k == 0) begin : g_head
         assign cell_d = d_in;
      end else begin : g_body
         assign cell_d = q[k-1];
      end

      dca_cell #(.W(W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .d_in    (cell_d),
         .q       (q[k]),
         .contrib (contrib[k])
      );
   end

   // Only the selected cell contributes, so an OR gathers the tap.
   always_comb begin
      tap_in = '0;
      for (int k = 0; k < DEPTH; k++) begin
         tap_in = tap_in | contrib[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign tap = tap_ff;

endmodule

`default_nettype wire

// File: rtl/dca_cmul.sv
// Three-stage conjugate multiply and power pipeline with per-stage flow
// control; drives the result channel. Depends on dca_pkg and dca_rsp_if.
`default_nettype none

module dca_cmul #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] x_re,
   input  wire logic signed [SAMPLE_BITS-1:0] x_im,
   input  wire logic signed [SAMPLE_BITS-1:0] d_re,
   input  wire logic signed [SAMPLE_BITS-1:0] d_im,
   dca_rsp_if.source                          rsp
);

   localparam int MulW = 2 * SAMPLE_BITS;
   localparam int SumW = (MulW + 1 > dca_pkg::ProductW) ? MulW + 1 : dca_pkg::ProductW;

   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   logic signed [SAMPLE_BITS-1:0] xr_ff, xi_ff, dr_ff, di_ff;
   logic signed [MulW-1:0]        rr_ff, ii_ff, ri_ff, ir_ff, sqr_ff, sqi_ff;
   logic signed [SumW-1:0]        sum_re, sum_im, sum_pw;

   logic signed [dca_pkg::ProductW-1:0] product_re_ff, product_im_ff;
   logic [dca_pkg::PowerW-1:0]          power_ff;

   // A stage moves when it is empty, or when the stage after it is empty or moving too.
   assign en3 = !v3_ff || rsp.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff    : v2_ff;
   assign v3_in = en3 ? v2_ff    : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         xr_ff <= x_re;
         xi_ff <= x_im;
         dr_ff <= d_re;
         di_ff <= d_im;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         rr_ff  <= dr_ff * xr_ff;
         ii_ff  <= di_ff * xi_ff;
         ri_ff  <= dr_ff * xi_ff;
         ir_ff  <= di_ff * xr_ff;
         sqr_ff <= xr_ff * xr_ff;
         sqi_ff <= xi_ff * xi_ff;
      end
   end

   assign sum_re = SumW'(rr_ff) + SumW'(ii_ff);
   assign sum_im = SumW'(ri_ff) - SumW'(ir_ff);
   assign sum_pw = SumW'(sqr_ff) + SumW'(sqi_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         product_re_ff <= sum_re[dca_pkg::ProductW-1:0];
         product_im_ff <= sum_im[dca_pkg::ProductW-1:0];
         power_ff      <= sum_pw[dca_pkg::PowerW-1:0];
      end
   end

   assign rsp.valid      = v3_ff;
   assign rsp.product_re = product_re_ff;
   assign rsp.product_im = product_im_ff;
   assign rsp.power      = power_ff;

endmodule

`default_nettype wire

// File: rtl/dca_checker.sv
// Port-level checks of the delayed conjugate autocorrelation block and the
// bind that attaches them to the top level. Depends on dca_pkg.
`default_nettype none

module dca_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready,
   input wire logic signed [dca_pkg::ProductW-1:0] rsp_product_re,
   input wire logic signed [dca_pkg::ProductW-1:0] rsp_product_im,
   input wire logic [dca_pkg::PowerW-1:0]          rsp_power
);

   // The registered tap must follow a new lag before the next sample item is taken.
   a_lag_settle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("sample item taken right after a lag write");

   // An accepted item whose result channel stays ready shows up as a valid result.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result item missing three cycles after its sample");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product_re)
         && $stable(rsp_product_im) && $stable(rsp_power))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item valid right after reset");

endmodule

bind delayed_conjugate_autocorrelation_top dca_checker u_dca_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .csr_valid      (csr_ch.valid),
   .csr_ready      (csr_ch.ready),
   .rsp_product_re (rsp_ch.product_re),
   .rsp_product_im (rsp_ch.product_im),
   .rsp_power      (rsp_ch.power)
);

`default_nettype wire
